### sv/svpd_pkg.sv
`default_nettype none

package svpd_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = 15;
   localparam int HORNER_STEPS  = 5;
   localparam int SINE_W        = 32;
   localparam int AB_W          = 33;
   localparam int T_W           = 35;

   localparam logic [30:0] HORNER_SEED = 31'd3864;

   typedef logic [30:0] coef_type;

   typedef struct packed {
      logic [30:0] x;
      logic [30:0] x2;
      logic [30:0] p;
      logic        neg;
   } sine_lane_type;

   typedef struct packed {
      sine_lane_type          sin_l;
      sine_lane_type          cos_l;
      logic signed [FRAC_BITS:0] d;
      logic signed [FRAC_BITS:0] q;
   } horner_type;

   function automatic coef_type horner_coef(input logic [2:0] step);
      coef_type c;
      case (step)
         3'd0: c = 31'd172272;
         3'd1: c = 31'd5026995;
         3'd2: c = 31'd85569306;
         3'd3: c = 31'd693598668;
         3'd4: c = 31'd1686629713;
         default: c = 31'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] sector_of_code(input logic [2:0] code);
      logic [2:0] k;
      case (code)
         3'd0: k = 3'd4;
         3'd1: k = 3'd6;
         3'd2: k = 3'd5;
         3'd3: k = 3'd5;
         3'd4: k = 3'd3;
         3'd5: k = 3'd1;
         3'd6: k = 3'd2;
         3'd7: k = 3'd2;
         default: k = 3'd4;
      endcase
      return k;
   endfunction

   function automatic logic signed [31:0] sin_k60(input logic [2:0] k);
      logic signed [31:0] v;
      case (k)
         3'd1, 3'd2: v = 32'sd929887698;
         3'd4, 3'd5: v = -32'sd929887698;
         default:    v = 32'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] cos_k60(input logic [2:0] k);
      logic signed [31:0] v;
      case (k)
         3'd0, 3'd6: v = 32'sd1073741824;
         3'd1, 3'd5: v = 32'sd536870912;
         3'd2, 3'd4: v = -32'sd536870912;
         3'd3:       v = -32'sd1073741824;
         default:    v = 32'sd0;
      endcase
      return v;
   endfunction

   // Switching pattern of each active vector, bits ordered U, V, W.
   function automatic logic [2:0] vec_on(input logic [2:0] idx);
      logic [2:0] v;
      case (idx)
         3'd0: v = 3'b100;
         3'd1: v = 3'b110;
         3'd2: v = 3'b010;
         3'd3: v = 3'b011;
         3'd4: v = 3'b001;
         3'd5: v = 3'b101;
         default: v = 3'b000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### sv/svpd_channels.sv
`default_nettype none

interface svpd_req_if;
   import svpd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [ANGLE_BITS-1:0]     angle;
   logic signed [FRAC_BITS:0] d_voltage;
   logic signed [FRAC_BITS:0] q_voltage;
   modport source (output valid, angle, d_voltage, q_voltage, input ready);
   modport sink   (input valid, angle, d_voltage, q_voltage, output ready);
endinterface

interface svpd_rsp_if;
   import svpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [FRAC_BITS:0] duty_u;
   logic [FRAC_BITS:0] duty_v;
   logic [FRAC_BITS:0] duty_w;
   logic               overmodulated;
   modport source (output valid, duty_u, duty_v, duty_w, overmodulated, input ready);
   modport sink   (input valid, duty_u, duty_v, duty_w, overmodulated, output ready);
endinterface

`default_nettype wire

### sv/svpd_horner_cell.sv
`default_nettype none

module svpd_horner_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  svpd_pkg::coef_type   coef,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  svpd_pkg::horner_type up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output svpd_pkg::horner_type dn_data
);
   import svpd_pkg::*;

   logic       valid_ff;
   horner_type data_ff;
   horner_type data_in;
   logic       take;
   logic [61:0] prod_sin;
   logic [61:0] prod_cos;

   assign take     = !valid_ff || dn_ready;
   assign up_ready = take;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // One Horner step on both the sine and the cosine lane.
   always_comb begin
      prod_sin = 62'(up_data.sin_l.p) * 62'(up_data.sin_l.x2);
      prod_cos = 62'(up_data.cos_l.p) * 62'(up_data.cos_l.x2);
      data_in = up_data;
      data_in.sin_l.p = coef - prod_sin[60:30];
      data_in.cos_l.p = coef - prod_cos[60:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= up_valid;
      end
      if (take) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### sv/space_vector_pwm_duty_core.sv
// Stages: lane set-up, Horner cells, sine, ab, squares, sector, times, output.
// Throughput: one item per cycle; every stage has its own valid bit and loads
// when it is empty or its content moves on, so a waiting result holds up the
// input only once all twelve stages are full.
// Reset clears every valid bit; the data registers are not reset.
`default_nettype none

module space_vector_pwm_duty_core (
   input  logic              clock,
   input  logic              reset,
   svpd_req_if.sink          req_ch,
   svpd_rsp_if.source        rsp_ch
);
   import svpd_pkg::*;

   localparam int PW = FRAC_BITS + 1 + SINE_W + 1;
   localparam int JW = 2 * SINE_W + 2;
   localparam int DW = T_W + 3;
   localparam int RS = 31 - FRAC_BITS;

   localparam logic signed [PW-1:0] A_HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [JW-1:0] J_HALF = JW'(1) << 29;
   localparam logic signed [DW-1:0] D_ONE  = DW'(1) << 30;
   localparam logic signed [DW-1:0] D_HALF = DW'(1) << (RS - 1);
   localparam logic signed [DW-1:0] D_FULL = DW'(1) << FRAC_BITS;

   // Lane set-up stage
   logic        lane_valid_ff;
   logic        lane_take;
   horner_type  lane_data_ff;
   horner_type  lane_data_in;
   logic [31:0] ph_sin;
   logic [31:0] ph_cos;

   // Horner chain
   horner_type h_data  [0:HORNER_STEPS];
   logic       h_valid [0:HORNER_STEPS];
   logic       h_ready [0:HORNER_STEPS];

   // Sine and cosine
   logic                      sine_valid_ff;
   logic                      sine_take;
   logic signed [SINE_W-1:0]  sine_s_ff;
   logic signed [SINE_W-1:0]  sine_c_ff;
   logic signed [FRAC_BITS:0] sine_d_ff;
   logic signed [FRAC_BITS:0] sine_q_ff;

   // Alpha and beta
   logic                    ab_valid_ff;
   logic                    ab_take;
   logic signed [AB_W-1:0]  ab_alpha_ff;
   logic signed [AB_W-1:0]  ab_beta_ff;
   logic signed [PW-1:0]    pa_in;
   logic signed [PW-1:0]    pb_in;

   // Squares
   logic                   sq_valid_ff;
   logic                   sq_take;
   logic signed [AB_W-1:0] sq_alpha_ff;
   logic signed [AB_W-1:0] sq_beta_ff;
   logic [63:0]            sq_ua2_ff;
   logic [63:0]            sq_ub2_ff;
   logic [31:0]            ua_in;
   logic [31:0]            ub_in;

   // Sector
   logic                   sec_valid_ff;
   logic                   sec_take;
   logic signed [AB_W-1:0] sec_alpha_ff;
   logic signed [AB_W-1:0] sec_beta_ff;
   logic [2:0]             sec_k_ff;
   logic [65:0]            three_ua2;
   logic [2:0]             code_in;

   // Active vector times
   logic                  tt_valid_ff;
   logic                  tt_take;
   logic signed [T_W-1:0] tt_tm_ff;
   logic signed [T_W-1:0] tt_tn_ff;
   logic [2:0]            tt_on_m_ff;
   logic [2:0]            tt_on_n_ff;
   logic signed [JW-1:0]  jm_in;
   logic signed [JW-1:0]  jn_in;
   logic [2:0]            k_prev;
   logic [2:0]            k_next;

   // Output register
   logic               out_valid_ff;
   logic               out_take;
   logic [FRAC_BITS:0] out_u_ff;
   logic [FRAC_BITS:0] out_v_ff;
   logic [FRAC_BITS:0] out_w_ff;
   logic               out_sat_ff;
   logic signed [DW-1:0] t0_in;
   logic [FRAC_BITS+1:0] du_in;
   logic [FRAC_BITS+1:0] dv_in;
   logic [FRAC_BITS+1:0] dw_in;

   function automatic sine_lane_type lane_of_phase(input logic [31:0] ph);
      sine_lane_type l;
      logic [61:0]   sq;
      l.x   = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
      sq    = 62'(l.x) * 62'(l.x);
      l.x2  = sq[60:30];
      l.p   = HORNER_SEED;
      l.neg = ph[31];
      return l;
   endfunction

   function automatic logic signed [SINE_W-1:0] lane_sine(input sine_lane_type l);
      logic [61:0]              prod;
      logic signed [SINE_W-1:0] mag;
      prod = 62'(l.p) * 62'(l.x);
      mag  = signed'(prod[61:30]);
      return l.neg ? -mag : mag;
   endfunction

   function automatic logic signed [DW-1:0] phase_time(
      input logic signed [T_W-1:0] tm,
      input logic signed [T_W-1:0] tn,
      input logic signed [DW-1:0]  t0,
      input logic                  bm,
      input logic                  bn
   );
      logic signed [DW-1:0] part;
      part = (bm ? DW'(tm) : DW'(0)) + (bn ? DW'(tn) : DW'(0));
      return (part <<< 1) + t0;
   endfunction

   // Rounds twice the duty to the output scale and saturates; MSB is the flag.
   function automatic logic [FRAC_BITS+1:0] duty_of(input logic signed [DW-1:0] twice);
      logic signed [DW-1:0] v;
      logic [FRAC_BITS+1:0] r;
      v = (twice + D_HALF) >>> RS;
      if (v < 0) begin
         r = {1'b1, (FRAC_BITS+1)'(0)};
      end else if (v > D_FULL) begin
         r = {1'b1, D_FULL[FRAC_BITS:0]};
      end else begin
         r = {1'b0, v[FRAC_BITS:0]};
      end
      return r;
   endfunction

   // Handshake: each stage loads when it is empty or its content moves on.
   assign out_take   = !out_valid_ff || rsp_ch.ready;
   assign tt_take    = !tt_valid_ff || out_take;
   assign sec_take   = !sec_valid_ff || tt_take;
   assign sq_take    = !sq_valid_ff || sec_take;
   assign ab_take    = !ab_valid_ff || sq_take;
   assign sine_take  = !sine_valid_ff || ab_take;
   assign lane_take  = !lane_valid_ff || h_ready[0];
   assign req_ch.ready = lane_take;

   assign h_valid[0]            = lane_valid_ff;
   assign h_data[0]             = lane_data_ff;
   assign h_ready[HORNER_STEPS] = sine_take;

   always_comb begin
      ph_sin = {req_ch.angle, (32-ANGLE_BITS)'(0)};
      ph_cos = ph_sin + 32'h4000_0000;
      lane_data_in.sin_l = lane_of_phase(ph_sin);
      lane_data_in.cos_l = lane_of_phase(ph_cos);
      lane_data_in.d     = req_ch.d_voltage;
      lane_data_in.q     = req_ch.q_voltage;
   end

   genvar gi;
   generate
      for (gi = 0; gi < HORNER_STEPS; gi++) begin : g_cell
         svpd_horner_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .coef     (horner_coef(3'(gi))),
            .up_valid (h_valid[gi]),
            .up_ready (h_ready[gi]),
            .up_data  (h_data[gi]),
            .dn_valid (h_valid[gi+1]),
            .dn_ready (h_ready[gi+1]),
            .dn_data  (h_data[gi+1])
         );
      end
   endgenerate

   always_comb begin
      pa_in = PW'(sine_d_ff) * PW'(sine_c_ff) - PW'(sine_q_ff) * PW'(sine_s_ff);
      pb_in = PW'(sine_d_ff) * PW'(sine_s_ff) + PW'(sine_q_ff) * PW'(sine_c_ff);
   end

   always_comb begin
      ua_in = ab_alpha_ff[AB_W-1] ? 32'(-ab_alpha_ff) : 32'(ab_alpha_ff);
      ub_in = ab_beta_ff[AB_W-1]  ? 32'(-ab_beta_ff)  : 32'(ab_beta_ff);
   end

   always_comb begin
      three_ua2 = {2'b00, sq_ua2_ff} + {1'b0, sq_ua2_ff, 1'b0};
      code_in   = {sq_beta_ff > 0, {2'b00, sq_ub2_ff} > three_ua2, sq_alpha_ff > 0};
   end

   always_comb begin
      k_prev = sec_k_ff - 3'd1;
      k_next = (sec_k_ff == 3'd6) ? 3'd0 : sec_k_ff;
      jm_in  = JW'(sin_k60(sec_k_ff)) * JW'(sec_alpha_ff)
             - JW'(cos_k60(sec_k_ff)) * JW'(sec_beta_ff);
      jn_in  = JW'(cos_k60(k_prev)) * JW'(sec_beta_ff)
             - JW'(sin_k60(k_prev)) * JW'(sec_alpha_ff);
   end

   always_comb begin
      t0_in = D_ONE - DW'(tt_tm_ff) - DW'(tt_tn_ff);
      du_in = duty_of(phase_time(tt_tm_ff, tt_tn_ff, t0_in, tt_on_m_ff[2], tt_on_n_ff[2]));
      dv_in = duty_of(phase_time(tt_tm_ff, tt_tn_ff, t0_in, tt_on_m_ff[1], tt_on_n_ff[1]));
      dw_in = duty_of(phase_time(tt_tm_ff, tt_tn_ff, t0_in, tt_on_m_ff[0], tt_on_n_ff[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         sine_valid_ff <= 1'b0;
         ab_valid_ff   <= 1'b0;
         sq_valid_ff   <= 1'b0;
         sec_valid_ff  <= 1'b0;
         tt_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (lane_take) lane_valid_ff <= req_ch.valid;
         if (sine_take) sine_valid_ff <= h_valid[HORNER_STEPS];
         if (ab_take)   ab_valid_ff   <= sine_valid_ff;
         if (sq_take)   sq_valid_ff   <= ab_valid_ff;
         if (sec_take)  sec_valid_ff  <= sq_valid_ff;
         if (tt_take)   tt_valid_ff   <= sec_valid_ff;
         if (out_take)  out_valid_ff  <= tt_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_take) begin
         lane_data_ff <= lane_data_in;
      end
      if (sine_take) begin
         sine_s_ff <= lane_sine(h_data[HORNER_STEPS].sin_l);
         sine_c_ff <= lane_sine(h_data[HORNER_STEPS].cos_l);
         sine_d_ff <= h_data[HORNER_STEPS].d;
         sine_q_ff <= h_data[HORNER_STEPS].q;
      end
      if (ab_take) begin
         ab_alpha_ff <= AB_W'((pa_in + A_HALF) >>> FRAC_BITS);
         ab_beta_ff  <= AB_W'((pb_in + A_HALF) >>> FRAC_BITS);
      end
      if (sq_take) begin
         sq_alpha_ff <= ab_alpha_ff;
         sq_beta_ff  <= ab_beta_ff;
         sq_ua2_ff   <= 64'(ua_in) * 64'(ua_in);
         sq_ub2_ff   <= 64'(ub_in) * 64'(ub_in);
      end
      if (sec_take) begin
         sec_alpha_ff <= sq_alpha_ff;
         sec_beta_ff  <= sq_beta_ff;
         sec_k_ff     <= sector_of_code(code_in);
      end
      if (tt_take) begin
         tt_tm_ff   <= T_W'((jm_in + J_HALF) >>> 30);
         tt_tn_ff   <= T_W'((jn_in + J_HALF) >>> 30);
         tt_on_m_ff <= vec_on(k_prev);
         tt_on_n_ff <= vec_on(k_next);
      end
      if (out_take) begin
         out_u_ff   <= du_in[FRAC_BITS:0];
         out_v_ff   <= dv_in[FRAC_BITS:0];
         out_w_ff   <= dw_in[FRAC_BITS:0];
         out_sat_ff <= du_in[FRAC_BITS+1] | dv_in[FRAC_BITS+1] | dw_in[FRAC_BITS+1];
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.duty_u        = out_u_ff;
   assign rsp_ch.duty_v        = out_v_ff;
   assign rsp_ch.duty_w        = out_w_ff;
   assign rsp_ch.overmodulated = out_sat_ff;

endmodule

`default_nettype wire
